[hdl/bptc_pkg.sv]
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared widths, constants, register indexes and types of the pressure and
// temperature compensation unit.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // Port widths.
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int OUT_T_W   = 15;
  localparam int OUT_P_W   = 17;
  localparam int CFG_IDX_W = 3;

  // Internal widths, sized to the value ranges of each term.
  localparam int DT_W    = RAW_W + 1;
  localparam int PT_W    = DT_W + COEF_W + 1;
  localparam int DD_W    = 2 * DT_W;
  localparam int A_W     = 18;
  localparam int B_W     = A_W + 1;
  localparam int TEMP_W  = 20;
  localparam int T2_W    = 17;
  localparam int SQ_W    = 35;
  localparam int OFF1_W  = 36;
  localparam int OFF2_W  = 40;
  localparam int OFF_W   = 41;
  localparam int SENS1_W = 35;
  localparam int SENS2_W = 39;
  localparam int SENS_W  = 40;
  localparam int SLO_W   = 20;
  localparam int SHI_W   = SENS_W - SLO_W;
  localparam int PPLO_W  = RAW_W + SLO_W;
  localparam int PPHI_W  = RAW_W + 1 + SHI_W;
  localparam int PROD_W  = 64;
  localparam int X_W     = 44;

  // Scaling shifts of the compensation formulas.
  localparam int TEMP_SHIFT    = 23;
  localparam int C5_SHIFT      = 8;
  localparam int OFF_C2_SHIFT  = 17;
  localparam int OFF_DT_SHIFT  = 6;
  localparam int SENS_C1_SHIFT = 16;
  localparam int SENS_DT_SHIFT = 7;
  localparam int T2_SHIFT      = 31;
  localparam int OFF2_SHIFT    = 4;
  localparam int PROD_SHIFT    = 21;
  localparam int PRESS_SHIFT   = 15;

  // Second order gains and temperature knees.
  localparam int OFF2_GAIN       = 61;
  localparam int OFF2_VLOW_GAIN  = 15;
  localparam int SENS2_GAIN      = 2;
  localparam int SENS2_VLOW_GAIN = 8;
  localparam int TEMP_REF        = 2000;
  localparam int TEMP_VLOW_KNEE  = -1500;
  localparam int A_VLOW          = TEMP_VLOW_KNEE - TEMP_REF;
  localparam int B_OFS           = TEMP_REF - TEMP_VLOW_KNEE;

  // Output saturation limits.
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRESS_MIN = 1000;
  localparam int PRESS_MAX = 120000;

  // Queue and pipeline sizes.
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = FIFO_AW + 1;
  localparam int BACK_STAGES = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

  // Calibration reset values.
  localparam logic [COEF_W-1:0] C1_RESET = 16'd46372;
  localparam logic [COEF_W-1:0] C2_RESET = 16'd43981;
  localparam logic [COEF_W-1:0] C3_RESET = 16'd29059;
  localparam logic [COEF_W-1:0] C4_RESET = 16'd27842;
  localparam logic [COEF_W-1:0] C5_RESET = 16'd31553;
  localparam logic [COEF_W-1:0] C6_RESET = 16'd28165;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coef_t;

  // One classified conversion pair as it travels through the queue.
  typedef struct packed {
    logic [RAW_W-1:0]       d1;
    logic signed [DT_W-1:0] dt;
  } item_t;

endpackage

[hdl/bptc_front.sv]
// ----------------------------------------------------------------------------
// Compensation front end
// Accepts a raw conversion pair, forms the temperature difference against
// the reference calibration word, and hands the word to the queue.
// ----------------------------------------------------------------------------
module bptc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bptc_pkg::RAW_W-1:0]    in_raw_temperature,
  input  logic [bptc_pkg::RAW_W-1:0]    in_raw_pressure,
  input  logic [bptc_pkg::COEF_W-1:0]   coef_c5,
  input  logic                          fifo_full,
  output logic                          fifo_push,
  output bptc_pkg::item_t               fifo_item
);

  logic            front_valid_r;
  logic            front_valid_nxt;
  bptc_pkg::item_t front_item_r;
  bptc_pkg::item_t front_item_nxt;
  logic            accept;

  assign fifo_push = front_valid_r && !fifo_full;
  assign in_stall  = front_valid_r && fifo_full;
  assign accept    = in_valid && !in_stall;
  assign fifo_item = front_item_r;

  always_comb begin
    front_valid_nxt   = accept || (front_valid_r && !fifo_push);
    front_item_nxt.d1 = in_raw_pressure;
    front_item_nxt.dt = $signed({1'b0, in_raw_temperature})
                      - $signed({1'b0, coef_c5, {bptc_pkg::C5_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item_r <= front_item_nxt;
    end
  end

endmodule

[hdl/bptc_fifo.sv]
// ----------------------------------------------------------------------------
// Compensation queue
// Short first-in first-out queue that decouples the front end from the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
module bptc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bptc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output bptc_pkg::item_t head,
  output logic            empty
);

  bptc_pkg::item_t                    mem_r [bptc_pkg::FIFO_DEPTH];
  logic [bptc_pkg::FIFO_AW-1:0]       wr_ptr_r;
  logic [bptc_pkg::FIFO_AW-1:0]       wr_ptr_nxt;
  logic [bptc_pkg::FIFO_AW-1:0]       rd_ptr_r;
  logic [bptc_pkg::FIFO_AW-1:0]       rd_ptr_nxt;
  logic [bptc_pkg::FIFO_CW-1:0]       count_r;
  logic [bptc_pkg::FIFO_CW-1:0]       count_nxt;

  assign full  = (count_r == bptc_pkg::FIFO_CW'(bptc_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hdl/bptc_back.sv]
// ----------------------------------------------------------------------------
// Compensation arithmetic pipeline
// Eight-stage pipeline that applies the first and second order compensation
// and saturates both results into the output register.
// ----------------------------------------------------------------------------
module bptc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bptc_pkg::coef_t                     coef,
  input  logic                                fifo_empty,
  input  bptc_pkg::item_t                     fifo_head,
  output logic                                fifo_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bptc_pkg::OUT_T_W-1:0] out_temperature_centi_c,
  output logic [bptc_pkg::OUT_P_W-1:0]        out_pressure_centi_mbar
);

  localparam int PT_W    = bptc_pkg::PT_W;
  localparam int A_W     = bptc_pkg::A_W;
  localparam int B_W     = bptc_pkg::B_W;
  localparam int TEMP_W  = bptc_pkg::TEMP_W;
  localparam int OFF1_W  = bptc_pkg::OFF1_W;
  localparam int OFF2_W  = bptc_pkg::OFF2_W;
  localparam int OFF_W   = bptc_pkg::OFF_W;
  localparam int SENS1_W = bptc_pkg::SENS1_W;
  localparam int SENS2_W = bptc_pkg::SENS2_W;
  localparam int SENS_W  = bptc_pkg::SENS_W;
  localparam int SQ_W    = bptc_pkg::SQ_W;
  localparam int X_W     = bptc_pkg::X_W;
  localparam int OUT_T_W = bptc_pkg::OUT_T_W;
  localparam int OUT_P_W = bptc_pkg::OUT_P_W;
  localparam int NSTG    = bptc_pkg::BACK_STAGES;

  logic                               adv;
  logic [NSTG-1:0]                    vld_r;
  logic [NSTG-1:0]                    vld_nxt;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic signed [bptc_pkg::DT_W-1:0]   dt_in;

  // Stage 1: products of the temperature difference.
  logic signed [PT_W-1:0]             s1_pt_r, s1_pt_nxt;
  logic signed [PT_W-1:0]             s1_poff_r, s1_poff_nxt;
  logic signed [PT_W-1:0]             s1_psens_r, s1_psens_nxt;
  logic signed [bptc_pkg::DD_W-1:0]   s1_pdd_r, s1_pdd_nxt;
  logic [bptc_pkg::RAW_W-1:0]         s1_d1_r;

  // Stage 2: first order terms.
  logic signed [A_W-1:0]              s2_a_r, s2_a_nxt;
  logic signed [TEMP_W-1:0]           s2_temp_r, s2_temp_nxt;
  logic signed [OFF1_W-1:0]           s2_off1_r, s2_off1_nxt;
  logic signed [SENS1_W-1:0]          s2_sens1_r, s2_sens1_nxt;
  logic [bptc_pkg::T2_W-1:0]          s2_t2_r, s2_t2_nxt;
  logic                               s2_low_r, s2_low_nxt;
  logic                               s2_vlow_r, s2_vlow_nxt;
  logic [bptc_pkg::RAW_W-1:0]         s2_d1_r;

  // Stage 3: squares of the temperature deviations.
  logic signed [B_W-1:0]              s3_b;
  logic signed [2*A_W-1:0]            s3_sqf;
  logic signed [2*B_W-1:0]            s3_sq2f;
  logic [SQ_W-1:0]                    s3_sq_r, s3_sq_nxt;
  logic [SQ_W-1:0]                    s3_sq2_r, s3_sq2_nxt;
  logic signed [TEMP_W-1:0]           s3_temp_r;
  logic signed [OFF1_W-1:0]           s3_off1_r;
  logic signed [SENS1_W-1:0]          s3_sens1_r;
  logic [bptc_pkg::T2_W-1:0]          s3_t2_r;
  logic                               s3_low_r;
  logic                               s3_vlow_r;
  logic [bptc_pkg::RAW_W-1:0]         s3_d1_r;

  // Stage 4: second order corrections.
  logic [OFF2_W+1:0]                  s4_sq61;
  logic [OFF2_W-1:0]                  s4_off2_r, s4_off2_nxt;
  logic [SENS2_W-1:0]                 s4_sens2_r, s4_sens2_nxt;
  logic signed [TEMP_W-1:0]           s4_temp_r, s4_temp_nxt;
  logic signed [OFF1_W-1:0]           s4_off1_r;
  logic signed [SENS1_W-1:0]          s4_sens1_r;
  logic [bptc_pkg::RAW_W-1:0]         s4_d1_r;

  // Stage 5: corrected offset and sensitivity, saturated temperature.
  logic signed [OFF_W-1:0]            s5_off_r, s5_off_nxt;
  logic signed [SENS_W-1:0]           s5_sens_r, s5_sens_nxt;
  logic signed [OUT_T_W-1:0]          s5_temp_r, s5_temp_nxt;
  logic [bptc_pkg::RAW_W-1:0]         s5_d1_r;

  // Stage 6 and 7: the wide pressure product in two partial products.
  logic [bptc_pkg::PPLO_W-1:0]        s6_pplo_r, s6_pplo_nxt;
  logic signed [bptc_pkg::PPHI_W-1:0] s6_pphi_r, s6_pphi_nxt;
  logic signed [OFF_W-1:0]            s6_off_r;
  logic signed [OUT_T_W-1:0]          s6_temp_r;
  logic signed [bptc_pkg::PROD_W-1:0] s7_prod_r, s7_prod_nxt;
  logic signed [OFF_W-1:0]            s7_off_r;
  logic signed [OUT_T_W-1:0]          s7_temp_r;

  // Stage 8: pressure and output register.
  logic signed [X_W-1:0]              s8_x;
  logic signed [X_W-1:0]              s8_p;
  logic signed [OUT_T_W-1:0]          out_temp_r;
  logic [OUT_P_W-1:0]                 out_press_r, out_press_nxt;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign fifo_pop = adv && !fifo_empty;
  assign dt_in    = fifo_head.dt;

  assign out_valid               = out_valid_r;
  assign out_temperature_centi_c = out_temp_r;
  assign out_pressure_centi_mbar = out_press_r;

  always_comb begin
    vld_nxt       = {vld_r[NSTG-2:0], fifo_pop};
    out_valid_nxt = vld_r[NSTG-1];

    s1_pt_nxt    = dt_in * $signed({1'b0, coef.c6});
    s1_poff_nxt  = dt_in * $signed({1'b0, coef.c4});
    s1_psens_nxt = dt_in * $signed({1'b0, coef.c3});
    s1_pdd_nxt   = dt_in * dt_in;

    s2_a_nxt     = s1_pt_r[bptc_pkg::TEMP_SHIFT+A_W-1:bptc_pkg::TEMP_SHIFT];
    s2_temp_nxt  = TEMP_W'(s2_a_nxt) + TEMP_W'(bptc_pkg::TEMP_REF);
    s2_off1_nxt  = $signed(OFF1_W'({coef.c2, {bptc_pkg::OFF_C2_SHIFT{1'b0}}}))
                 + OFF1_W'(s1_poff_r >>> bptc_pkg::OFF_DT_SHIFT);
    s2_sens1_nxt = $signed(SENS1_W'({coef.c1, {bptc_pkg::SENS_C1_SHIFT{1'b0}}}))
                 + SENS1_W'(s1_psens_r >>> bptc_pkg::SENS_DT_SHIFT);
    s2_t2_nxt    = s1_pdd_r[bptc_pkg::T2_SHIFT+bptc_pkg::T2_W-1:bptc_pkg::T2_SHIFT];
    // Below the reference temperature the deviation is negative.
    s2_low_nxt   = s2_a_nxt[A_W-1];
    s2_vlow_nxt  = (s2_a_nxt < A_W'(bptc_pkg::A_VLOW));

    s3_b       = B_W'(s2_a_r) + B_W'(bptc_pkg::B_OFS);
    s3_sqf     = s2_a_r * s2_a_r;
    s3_sq2f    = s3_b * s3_b;
    s3_sq_nxt  = SQ_W'($unsigned(s3_sqf));
    s3_sq2_nxt = SQ_W'($unsigned(s3_sq2f));

    s4_sq61      = (OFF2_W+2)'(s3_sq_r) * (OFF2_W+2)'(bptc_pkg::OFF2_GAIN);
    s4_off2_nxt  = '0;
    s4_sens2_nxt = '0;
    s4_temp_nxt  = s3_temp_r;
    if (s3_low_r) begin
      s4_off2_nxt  = OFF2_W'(s4_sq61 >> bptc_pkg::OFF2_SHIFT)
                   + (s3_vlow_r ? OFF2_W'(s3_sq2_r) * OFF2_W'(bptc_pkg::OFF2_VLOW_GAIN)
                                : '0);
      s4_sens2_nxt = SENS2_W'(s3_sq_r) * SENS2_W'(bptc_pkg::SENS2_GAIN)
                   + (s3_vlow_r ? SENS2_W'(s3_sq2_r) * SENS2_W'(bptc_pkg::SENS2_VLOW_GAIN)
                                : '0);
      s4_temp_nxt  = s3_temp_r - $signed(TEMP_W'(s3_t2_r));
    end

    s5_off_nxt  = OFF_W'(s4_off1_r) - $signed(OFF_W'(s4_off2_r));
    s5_sens_nxt = SENS_W'(s4_sens1_r) - $signed(SENS_W'(s4_sens2_r));
    if (s4_temp_r < TEMP_W'(bptc_pkg::TEMP_MIN)) begin
      s5_temp_nxt = OUT_T_W'(bptc_pkg::TEMP_MIN);
    end else if (s4_temp_r > TEMP_W'(bptc_pkg::TEMP_MAX)) begin
      s5_temp_nxt = OUT_T_W'(bptc_pkg::TEMP_MAX);
    end else begin
      s5_temp_nxt = s4_temp_r[OUT_T_W-1:0];
    end

    s6_pplo_nxt = bptc_pkg::PPLO_W'(s5_d1_r)
                * bptc_pkg::PPLO_W'(s5_sens_r[bptc_pkg::SLO_W-1:0]);
    s6_pphi_nxt = $signed({1'b0, s5_d1_r}) * $signed(s5_sens_r[SENS_W-1:bptc_pkg::SLO_W]);

    s7_prod_nxt = (bptc_pkg::PROD_W'(s6_pphi_r) <<< bptc_pkg::SLO_W)
                + $signed(bptc_pkg::PROD_W'(s6_pplo_r));

    s8_x = X_W'(s7_prod_r >>> bptc_pkg::PROD_SHIFT) - X_W'(s7_off_r);
    s8_p = s8_x >>> bptc_pkg::PRESS_SHIFT;
    if (s8_p < X_W'(bptc_pkg::PRESS_MIN)) begin
      out_press_nxt = OUT_P_W'(bptc_pkg::PRESS_MIN);
    end else if (s8_p > X_W'(bptc_pkg::PRESS_MAX)) begin
      out_press_nxt = OUT_P_W'(bptc_pkg::PRESS_MAX);
    end else begin
      out_press_nxt = s8_p[OUT_P_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt_r    <= s1_pt_nxt;
      s1_poff_r  <= s1_poff_nxt;
      s1_psens_r <= s1_psens_nxt;
      s1_pdd_r   <= s1_pdd_nxt;
      s1_d1_r    <= fifo_head.d1;

      s2_a_r     <= s2_a_nxt;
      s2_temp_r  <= s2_temp_nxt;
      s2_off1_r  <= s2_off1_nxt;
      s2_sens1_r <= s2_sens1_nxt;
      s2_t2_r    <= s2_t2_nxt;
      s2_low_r   <= s2_low_nxt;
      s2_vlow_r  <= s2_vlow_nxt;
      s2_d1_r    <= s1_d1_r;

      s3_sq_r    <= s3_sq_nxt;
      s3_sq2_r   <= s3_sq2_nxt;
      s3_temp_r  <= s2_temp_r;
      s3_off1_r  <= s2_off1_r;
      s3_sens1_r <= s2_sens1_r;
      s3_t2_r    <= s2_t2_r;
      s3_low_r   <= s2_low_r;
      s3_vlow_r  <= s2_vlow_r;
      s3_d1_r    <= s2_d1_r;

      s4_off2_r  <= s4_off2_nxt;
      s4_sens2_r <= s4_sens2_nxt;
      s4_temp_r  <= s4_temp_nxt;
      s4_off1_r  <= s3_off1_r;
      s4_sens1_r <= s3_sens1_r;
      s4_d1_r    <= s3_d1_r;

      s5_off_r   <= s5_off_nxt;
      s5_sens_r  <= s5_sens_nxt;
      s5_temp_r  <= s5_temp_nxt;
      s5_d1_r    <= s4_d1_r;

      s6_pplo_r  <= s6_pplo_nxt;
      s6_pphi_r  <= s6_pphi_nxt;
      s6_off_r   <= s5_off_r;
      s6_temp_r  <= s5_temp_r;

      s7_prod_r  <= s7_prod_nxt;
      s7_off_r   <= s6_off_r;
      s7_temp_r  <= s6_temp_r;

      out_press_r <= out_press_nxt;
      out_temp_r  <= s7_temp_r;
    end
  end

endmodule

[hdl/baro_pressure_temperature_compensation_unit.sv]
// ----------------------------------------------------------------------------
// Barometric pressure and temperature compensation unit
// Second order compensation of raw sensor conversions with six calibration
// words held in configuration registers.
// ----------------------------------------------------------------------------
// Each word on the input channel is one raw temperature and one raw pressure
// conversion; each word on the output channel is the compensated temperature
// in hundredths of a degree and pressure in hundredths of a millibar, both
// saturated to the sensor range. The unit takes one word per clock cycle in
// steady state: a front register feeds a four-entry queue, which feeds an
// eight-stage arithmetic pipeline ending in the output register. A stall on
// the output holds the whole pipeline; the queue and the front register then
// absorb up to five more words before in_stall rises. Calibration words are
// written through the cfg port, which is always ready, and must only change
// while the unit is empty; writes to indexes six and seven are dropped.
module baro_pressure_temperature_compensation_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bptc_pkg::RAW_W-1:0]           in_raw_temperature,
  input  logic [bptc_pkg::RAW_W-1:0]           in_raw_pressure,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bptc_pkg::OUT_T_W-1:0]  out_temperature_centi_c,
  output logic [bptc_pkg::OUT_P_W-1:0]         out_pressure_centi_mbar,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bptc_pkg::COEF_W-1:0]          cfg_data
);

  bptc_pkg::coef_t coef_r;
  bptc_pkg::coef_t coef_nxt;
  bptc_pkg::item_t push_item;
  bptc_pkg::item_t head_item;
  logic            fifo_full;
  logic            fifo_push;
  logic            fifo_empty;
  logic            fifo_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bptc_pkg::REG_C1: coef_nxt.c1 = cfg_data;
        bptc_pkg::REG_C2: coef_nxt.c2 = cfg_data;
        bptc_pkg::REG_C3: coef_nxt.c3 = cfg_data;
        bptc_pkg::REG_C4: coef_nxt.c4 = cfg_data;
        bptc_pkg::REG_C5: coef_nxt.c5 = cfg_data;
        bptc_pkg::REG_C6: coef_nxt.c6 = cfg_data;
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.c1 <= bptc_pkg::C1_RESET;
      coef_r.c2 <= bptc_pkg::C2_RESET;
      coef_r.c3 <= bptc_pkg::C3_RESET;
      coef_r.c4 <= bptc_pkg::C4_RESET;
      coef_r.c5 <= bptc_pkg::C5_RESET;
      coef_r.c6 <= bptc_pkg::C6_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  bptc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .coef_c5            (coef_r.c5),
    .fifo_full          (fifo_full),
    .fifo_push          (fifo_push),
    .fifo_item          (push_item)
  );

  bptc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .head      (head_item),
    .empty     (fifo_empty)
  );

  bptc_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .coef                    (coef_r),
    .fifo_empty              (fifo_empty),
    .fifo_head               (head_item),
    .fifo_pop                (fifo_pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_temperature_centi_c (out_temperature_centi_c),
    .out_pressure_centi_mbar (out_pressure_centi_mbar)
  );

endmodule
